// ===== sv/morse_key_symbol_assembler_macros.svh =====
// assertion macros used by the morse key symbol assembler tick core
`ifndef MORSE_KEY_SYMBOL_ASSEMBLER_MACROS_SVH
`define MORSE_KEY_SYMBOL_ASSEMBLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msa_pkg.sv =====
// shared types and constants for the morse key symbol assembler
`timescale 1ns / 1ps

package msa_pkg;

    localparam int CFG_W  = 16;
    localparam int CODE_W = 2;
    localparam int IDX_W  = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_LONG_THR  = 2'd0,
        CFG_PAUSE_THR = 2'd1,
        CFG_LONG_CODE = 2'd2,
        CFG_SHORT_CODE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  long_thr;
        logic [CFG_W-1:0]  pause_thr;
        logic [CODE_W-1:0] long_code;
        logic [CODE_W-1:0] short_code;
    } t_cfg;

    localparam logic [CFG_W-1:0]  LONG_THR_RST   = 16'd3;
    localparam logic [CFG_W-1:0]  PAUSE_THR_RST  = 16'd6;
    localparam logic [CODE_W-1:0] LONG_CODE_RST  = 2'd2;
    localparam logic [CODE_W-1:0] SHORT_CODE_RST = 2'd1;

endpackage

// ===== sv/msa_cfg_regs.sv =====
// configuration register file of the morse key symbol assembler
`timescale 1ns / 1ps

module msa_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  msa_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [msa_pkg::CFG_W-1:0] i_cfg_data,
    output msa_pkg::t_cfg         o_cfg
);
    import msa_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_thr   <= LONG_THR_RST;
            r_cfg.pause_thr  <= PAUSE_THR_RST;
            r_cfg.long_code  <= LONG_CODE_RST;
            r_cfg.short_code <= SHORT_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LONG_THR:   r_cfg.long_thr   <= i_cfg_data;
                CFG_PAUSE_THR:  r_cfg.pause_thr  <= i_cfg_data;
                CFG_LONG_CODE:  r_cfg.long_code  <= i_cfg_data[CODE_W-1:0];
                CFG_SHORT_CODE: r_cfg.short_code <= i_cfg_data[CODE_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/msa_tick_core.sv =====
// per-tick timing state and symbol word update
`timescale 1ns / 1ps
`include "morse_key_symbol_assembler_macros.svh"

module msa_tick_core #(
    parameter int MAX_SYMBOLS = 6,
    parameter int TICK_BITS   = 16,
    parameter int WORD_W      = 2 * MAX_SYMBOLS,
    parameter int CNT_W       = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_key,
    input  msa_pkg::t_cfg     i_cfg,
    output logic              o_word_ready,
    output logic [WORD_W-1:0] o_code_bits,
    output logic [CNT_W-1:0]  o_symbols,
    output logic              o_key_held,
    output logic              o_word_pending
);
    import msa_pkg::*;

    localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [TICK_BITS-1:0] r_press, n_press;
    logic [TICK_BITS-1:0] r_release, n_release;
    logic                 r_in_press, n_in_press;
    logic                 r_await, n_await;
    logic [WORD_W-1:0]    r_word, n_word;
    logic [CNT_W-1:0]     r_sym_total, n_sym_total;

    logic                 press_edge;
    logic                 release_edge;
    logic [TICK_BITS-1:0] press_len;
    logic [TICK_BITS-1:0] idle_len;
    logic [CODE_W-1:0]    sym_code;
    logic                 pause_hit;
    logic [WORD_W-1:0]    app_word;
    logic [CNT_W-1:0]     app_total;

    always_comb begin
        press_edge   = !r_in_press && i_key;
        release_edge = r_in_press && !i_key;
        press_len    = r_tick - r_press;
        sym_code     = (CMP_W'(press_len) > CMP_W'(i_cfg.long_thr)) ?
                       i_cfg.long_code : i_cfg.short_code;

        // append, or wipe the word when it is already full
        app_word  = r_word;
        app_total = r_sym_total + CNT_W'(1);
        if (r_sym_total >= CNT_W'(MAX_SYMBOLS)) begin
            app_word  = '0;
            app_total = '0;
        end else begin
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                if (r_sym_total == CNT_W'(k)) begin
                    app_word[2*k +: CODE_W] = r_word[2*k +: CODE_W] | sym_code;
                end
            end
        end

        n_in_press  = r_in_press;
        n_press     = r_press;
        n_release   = r_release;
        n_await     = r_await;
        n_word      = r_word;
        n_sym_total = r_sym_total;

        if (press_edge) begin
            n_in_press = 1'b1;
            n_press    = r_tick;
            n_await    = 1'b0;
        end else if (release_edge) begin
            n_in_press  = 1'b0;
            n_release   = r_tick;
            n_await     = 1'b1;
            n_word      = app_word;
            n_sym_total = app_total;
        end

        idle_len  = r_tick - n_release;
        pause_hit = n_await && (CMP_W'(idle_len) > CMP_W'(i_cfg.pause_thr));

        o_word_ready = pause_hit;
        o_code_bits  = pause_hit ? n_word : '0;
        o_symbols    = pause_hit ? n_sym_total : '0;

        if (pause_hit) begin
            n_word      = '0;
            n_sym_total = '0;
            n_await     = 1'b0;
        end

        n_tick         = r_tick + TICK_BITS'(1);
        o_key_held     = n_in_press;
        o_word_pending = (n_word != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_press     <= '0;
            r_release   <= '0;
            r_in_press  <= 1'b0;
            r_await     <= 1'b0;
            r_word      <= '0;
            r_sym_total <= '0;
        end else if (i_step) begin
            r_tick      <= n_tick;
            r_press     <= n_press;
            r_release   <= n_release;
            r_in_press  <= n_in_press;
            r_await     <= n_await;
            r_word      <= n_word;
            r_sym_total <= n_sym_total;
        end
    end

    `MSA_ASSERT_NOW(a_count_bound, 1'b1, r_sym_total <= CNT_W'(MAX_SYMBOLS), "symbol count overflow")
    `MSA_ASSERT_NEXT(a_emit_clears, i_step && pause_hit, (r_word == '0) && (r_sym_total == '0) && !r_await, "word not cleared on emit")
    `MSA_ASSERT_NEXT(a_tick_holds, !i_step, $stable(r_tick) && $stable(r_word), "state moved without a tick")
    `MSA_ASSERT_NEXT(a_tick_advances, i_step, r_tick == TICK_BITS'($past(r_tick) + TICK_BITS'(1)), "tick count skipped")

endmodule

// ===== sv/morse_key_symbol_assembler.sv =====
// Morse key symbol assembler: one key sample per tick request in, one status result out.
// Slave channel: each request is one timer tick, tdata[0] is the sampled key level.
// Master channel: one result per tick; tuser[0] flags a finished code word, tdata
// carries the word, its symbol count and the key and pending status.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data write long_threshold (0),
// pause_threshold (1), long_code (2) and short_code (3); write only while idle.
// An accepted request is captured in the input register; its result is computed
// from the input register and lands in the output register.
// Throughput: one request per cycle unless the master side stalls; the whole tick update
// is a single registered pass (two subtracts, two compares and the word append) between
// the two registers. If the master side stalls the output register holds its result, the
// input register takes one more request, then o_s_axis_tready drops until space frees.
// Reset (synchronous, active low) clears the tick counter, timestamps, word,
// both valid flags and loads the register defaults 3, 6, 2, 1.
`timescale 1ns / 1ps

module morse_key_symbol_assembler #(
    parameter int MAX_SYMBOLS = 6,
    parameter int TICK_BITS   = 16,
    parameter int WORD_W      = 2 * MAX_SYMBOLS,
    parameter int CNT_W       = $clog2(MAX_SYMBOLS + 1),
    parameter int OUT_W       = WORD_W + CNT_W + 2,
    parameter int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write port
    input  logic                      i_cfg_we,
    input  msa_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [msa_pkg::CFG_W-1:0] i_cfg_data,
    // tick requests
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,  // [0] key_pressed
    // results
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // code_bits, symbols_in_word, key_held, word_pending, zero pad
    output logic [OUT_BYTES_W-1:0]    o_m_axis_tdata,
    output logic                      o_m_axis_tuser   // [0] word_ready
);
    import msa_pkg::*;

    t_cfg cfg;

    logic                   r_in_valid;
    logic                   r_in_key;
    logic                   r_out_valid;
    logic                   r_out_user;
    logic [OUT_BYTES_W-1:0] r_out_data, n_out_data;
    logic                   advance;

    logic              word_ready;
    logic [WORD_W-1:0] code_bits;
    logic [CNT_W-1:0]  symbols;
    logic              key_held;
    logic              word_pending;

    msa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    msa_tick_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .TICK_BITS   (TICK_BITS),
        .WORD_W      (WORD_W),
        .CNT_W       (CNT_W)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_key          (r_in_key),
        .i_cfg          (cfg),
        .o_word_ready   (word_ready),
        .o_code_bits    (code_bits),
        .o_symbols      (symbols),
        .o_key_held     (key_held),
        .o_word_pending (word_pending)
    );

    // input stage moves on whenever the output register is free or being drained
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_out_data                          = '0;
        n_out_data[WORD_W-1:0]              = code_bits;
        n_out_data[WORD_W +: CNT_W]         = symbols;
        n_out_data[WORD_W + CNT_W]          = key_held;
        n_out_data[WORD_W + CNT_W + 1]      = word_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_key <= i_s_axis_tdata[0];
        end
        if (advance) begin
            r_out_user <= word_ready;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ===== test/morse_key_symbol_assembler_test.sv =====
// testbench for the morse key symbol assembler: tick requests checked against a tick predictor
`timescale 1ns / 1ps

module morse_key_symbol_assembler_test;
    import msa_pkg::*;

    localparam int NSYM       = 6;
    localparam int WORD_W     = 2 * NSYM;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_TICKS = 200;

    typedef struct packed {
        logic              ready;
        logic [WORD_W-1:0] code_bits;
        logic [2:0]        nsyms;
        logic              held;
        logic              pending;
    } t_tick_result;

    // one table row: reps x (press_len ticks pressed, then gap_len ticks released)
    typedef struct packed {
        int unsigned  press_len;
        int unsigned  gap_len;
        int unsigned  reps;
        bit           typed;
        t_tick_result want;
    } t_row;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              cfg_we   = 1'b0;
    t_cfg_idx          cfg_idx  = CFG_LONG_THR;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_valid  = 1'b0;
    logic [7:0]        s_data   = '0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready  = 1'b0;
    logic [23:0]       m_data;
    logic              m_user;

    morse_key_symbol_assembler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [0] key_pressed
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [11:0] code_bits, [14:12] symbols_in_word, [15] key_held, [16] word_pending
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)    // [0] word_ready
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    t_cfg              cfg;
    logic [15:0]       tick_cnt, press_stamp, release_stamp;
    bit                pressing, pause_armed;
    logic [WORD_W-1:0] word;
    logic [2:0]        nsym;

    t_tick_result results_due[$];
    int unsigned  ticks_sent;
    int unsigned  mismatches;
    int unsigned  burst_left;
    bit           paced;
    bit           valid_want;

    t_row dir_rows [13] = '{
        '{0, 1, 1, 1'b1, '{1'b0, 12'h000, 3'd0, 1'b0, 1'b0}},
        '{2, 1, 1, 1'b1, '{1'b0, 12'h000, 3'd0, 1'b0, 1'b1}},
        '{5, 3, 1, 1'b0, '0},
        '{1, 1, 1, 1'b0, '0},  // press lands while the pause is still running
        '{4, 2, 3, 1'b0, '0},
        '{0, 6, 1, 1'b1, '{1'b1, 12'ha99, 3'd6, 1'b0, 1'b0}},
        '{1, 1, 7, 1'b1, '{1'b0, 12'h000, 3'd0, 1'b0, 1'b0}},  // seventh symbol wipes the word
        '{0, 7, 1, 1'b1, '{1'b1, 12'h000, 3'd0, 1'b0, 1'b0}},
        '{4, 1, 1, 1'b1, '{1'b0, 12'h000, 3'd0, 1'b0, 1'b1}},  // long press into an empty word
        '{3, 1, 1, 1'b0, '0},
        '{4, 7, 1, 1'b0, '0},
        '{0, 1, 1, 1'b0, '0},
        '{1, 8, 1, 1'b0, '0}
    };

    function automatic t_tick_result step_key_tick(bit key);
        t_tick_result r;
        logic [15:0]  held_len;
        logic [15:0]  idle_len;
        logic [1:0]   code;
        r = '0;
        if (!pressing && key) begin
            pressing    = 1'b1;
            press_stamp = tick_cnt;
            pause_armed = 1'b0;
        end else if (pressing && !key) begin
            held_len      = tick_cnt - press_stamp;
            pressing      = 1'b0;
            release_stamp = tick_cnt;
            pause_armed   = 1'b1;
            code = (held_len > cfg.long_thr) ? cfg.long_code : cfg.short_code;
            if (nsym >= NSYM) begin
                word = '0;
                nsym = '0;
            end else begin
                word = word | (WORD_W'(code) << (2 * nsym));
                nsym = nsym + 3'd1;
            end
        end
        idle_len = tick_cnt - release_stamp;
        if (pause_armed && idle_len > cfg.pause_thr) begin
            r.ready     = 1'b1;
            r.code_bits = word;
            r.nsyms     = nsym;
            word        = '0;
            nsym        = '0;
            pause_armed = 1'b0;
        end
        tick_cnt  = tick_cnt + 16'd1;
        r.held    = pressing;
        r.pending = (word != '0);
        return r;
    endfunction

    task automatic set_valid(bit v);
        if (v != valid_want) begin
            valid_want = v;
            s_valid <= v;
        end
    endtask

    task automatic drain_results();
        set_valid(1'b0);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_tick(bit key, bit use_typed = 1'b0, t_tick_result typed_val = '0);
        t_tick_result r;
        int unsigned  gap;
        set_valid(1'b1);
        s_data <= {7'b0, key};
        do @(posedge i_clk); while (!s_ready);
        r = step_key_tick(key);
        results_due.push_back(use_typed ? typed_val : r);
        ticks_sent++;
        if (paced) begin
            if ($urandom_range(0, 63) == 0) begin
                drain_results();
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    set_valid(1'b0);
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_config(t_cfg c);
        t_cfg_idx idx;
        idx = idx.first();
        repeat (4) begin
            cfg_we  <= 1'b1;
            cfg_idx <= idx;
            case (idx)
                CFG_LONG_THR:   cfg_data <= c.long_thr;
                CFG_PAUSE_THR:  cfg_data <= c.pause_thr;
                // upper bits carry junk that the block must ignore
                CFG_LONG_CODE:  cfg_data <= {14'($urandom()), c.long_code};
                CFG_SHORT_CODE: cfg_data <= {14'($urandom()), c.short_code};
                default:        cfg_data <= '0;
            endcase
            @(posedge i_clk);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        cfg = c;
    endtask

    function automatic int unsigned span_near(logic [15:0] thr);
        return $urandom_range(1, ((thr > 16'd30) ? 30 : int'(thr)) + 6);
    endfunction

    task automatic run_random(int unsigned n);
        int unsigned start;
        int unsigned plen;
        int unsigned glen;
        start = ticks_sent;
        while (ticks_sent - start < n) begin
            if ($urandom_range(0, 9) < 8) begin
                plen = span_near(cfg.long_thr);
                glen = span_near(cfg.pause_thr);
                repeat (plen) send_tick(1'b1);
                repeat (glen) send_tick(1'b0);
            end else begin
                repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        t_row rw;
        t_cfg nc;
        cfg = '{long_thr: LONG_THR_RST, pause_thr: PAUSE_THR_RST,
                long_code: LONG_CODE_RST, short_code: SHORT_CODE_RST};
        tick_cnt = '0; press_stamp = '0; release_stamp = '0;
        pressing = 1'b0; pause_armed = 1'b0; word = '0; nsym = '0;
        ticks_sent = 0; burst_left = 0; paced = 1'b1; valid_want = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(dir_rows); i++) begin
            rw = dir_rows[i];
            for (int k = 0; k < int'(rw.reps); k++) begin
                repeat (rw.press_len) send_tick(1'b1);
                for (int g = 0; g < int'(rw.gap_len); g++)
                    send_tick(1'b0, rw.typed && k == int'(rw.reps) - 1
                              && g == int'(rw.gap_len) - 1, rw.want);
            end
        end
        drain_results();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: nc = '{long_thr: 16'd0, pause_thr: 16'd0, long_code: 2'd3, short_code: 2'd0};
                1: nc = '{long_thr: 16'hffff, pause_thr: 16'hffff,
                          long_code: 2'd0, short_code: 2'd3};
                2: nc = '{long_thr: 16'd1, pause_thr: 16'd1, long_code: 2'd1, short_code: 2'd2};
                default: nc = '{long_thr: 16'($urandom_range(0, 12)),
                                pause_thr: 16'($urandom_range(0, 24)),
                                long_code: 2'($urandom()), short_code: 2'($urandom())};
            endcase
            write_config(nc);
            paced = (ph != 2);
            run_random(PHASE_TICKS);
            drain_results();
        end

        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("morse_key_symbol_assembler: match");
        else
            $display("morse_key_symbol_assembler: mismatch");
        $finish;
    end

    // receiver: runs of always ready, random ready and full stall
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 12);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        t_tick_result got;
        t_tick_result want;
        if (i_rst_n && m_valid && m_ready) begin
            got = '{ready: m_user, code_bits: m_data[11:0], nsyms: m_data[14:12],
                    held: m_data[15], pending: m_data[16]};
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ready=%0d code=%03h syms=%0d held=%0d pend=%0d",
                             got.ready, got.code_bits, got.nsyms, got.held, got.pending);
            end else begin
                want = results_due.pop_front();
                if (got != want || m_data[23:17] != '0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: expected ready=%0d code=%03h syms=%0d ",
                                  "held=%0d pend=%0d, got ready=%0d code=%03h syms=%0d ",
                                  "held=%0d pend=%0d pad=%02h"},
                                 want.ready, want.code_bits, want.nsyms, want.held,
                                 want.pending, got.ready, got.code_bits, got.nsyms,
                                 got.held, got.pending, m_data[23:17]);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    int unsigned idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("morse_key_symbol_assembler: mismatch");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/msa_pkg.sv
sv/msa_cfg_regs.sv
sv/msa_tick_core.sv
sv/morse_key_symbol_assembler.sv
test/morse_key_symbol_assembler_test.sv
